// File: rtl/mrlb_pkg.sv
// shared types, constants and controller command codes for the line breaker
package mrlb_pkg;

  localparam int unsigned MaxWords  = 64;
  localparam int unsigned IdxW      = $clog2(MaxWords);
  localparam int unsigned CntW      = IdxW + 1;
  localparam int unsigned SumW      = 14;
  localparam int unsigned CostW     = 24;
  localparam int unsigned AddrW     = 2 * IdxW;
  localparam logic [CostW-1:0] CostMax   = 24'hFFFFFF;
  localparam logic [CostW-1:0] WideCost  = 24'd65535;

  // datapath operation codes
  localparam logic [3:0] OP_NONE  = 4'd0;
  localparam logic [3:0] OP_LOAD  = 4'd1;
  localparam logic [3:0] OP_FINIT = 4'd2;
  localparam logic [3:0] OP_SRD   = 4'd3;
  localparam logic [3:0] OP_SEVAL = 4'd4;
  localparam logic [3:0] OP_SPLIT = 4'd5;
  localparam logic [3:0] OP_NEXT  = 4'd6;
  localparam logic [3:0] OP_WINIT = 4'd7;
  localparam logic [3:0] OP_WTOT  = 4'd8;
  localparam logic [3:0] OP_WRD   = 4'd9;
  localparam logic [3:0] OP_WCHK  = 4'd10;
  localparam logic [3:0] OP_EMIT  = 4'd11;
  localparam logic [3:0] OP_POP   = 4'd12;

  typedef struct packed {
    logic [7:0] word_length;
    logic       last_word;
  } word_item_t;

  typedef struct packed {
    logic [5:0]  word_index;
    logic        ends_line;
    logic [23:0] total_cost;
    logic        last_result;
  } result_t;

  typedef struct packed {
    logic [3:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic span_short;
    logic split_done;
    logic last_i;
    logic last_len;
    logic leaf;
    logic span_end;
    logic stack_empty;
  } dp_stat_t;

endpackage

// File: rtl/mrlb_ctrl.sv
// controller state machine sequencing load, table fill and walk
module mrlb_ctrl import mrlb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  logic     last_word_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     busy
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FINIT = 4'd1;
  localparam logic [3:0] S_SRD   = 4'd2;
  localparam logic [3:0] S_SEVAL = 4'd3;
  localparam logic [3:0] S_SPLIT = 4'd4;
  localparam logic [3:0] S_NEXT  = 4'd5;
  localparam logic [3:0] S_WINIT = 4'd6;
  localparam logic [3:0] S_WTOT  = 4'd7;
  localparam logic [3:0] S_WRD   = 4'd8;
  localparam logic [3:0] S_WCHK  = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;
  localparam logic [3:0] S_POP   = 4'd11;

  logic [3:0] state_q, state_d;

  assign busy = (state_q != S_IDLE);

  // next state and command
  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.op = OP_LOAD;
          if (last_word_i) state_d = S_FINIT;
        end
      end
      S_FINIT: begin
        cmd_o.op = OP_FINIT;
        state_d  = S_SRD;
      end
      S_SRD: begin
        cmd_o.op = OP_SRD;
        state_d  = S_SEVAL;
      end
      S_SEVAL: begin
        cmd_o.op = OP_SEVAL;
        state_d  = stat_i.span_short ? S_NEXT : S_SPLIT;
      end
      S_SPLIT: begin
        cmd_o.op = OP_SPLIT;
        if (stat_i.split_done) state_d = S_NEXT;
      end
      S_NEXT: begin
        cmd_o.op = OP_NEXT;
        state_d  = (stat_i.last_i && stat_i.last_len) ? S_WINIT : S_SRD;
      end
      S_WINIT: begin
        cmd_o.op = OP_WINIT;
        state_d  = S_WTOT;
      end
      S_WTOT: begin
        cmd_o.op = OP_WTOT;
        state_d  = S_WRD;
      end
      S_WRD: begin
        cmd_o.op = OP_WRD;
        state_d  = S_WCHK;
      end
      S_WCHK: begin
        cmd_o.op = OP_WCHK;
        state_d  = stat_i.leaf ? S_EMIT : S_WRD;
      end
      S_EMIT: begin
        cmd_o.op = OP_EMIT;
        if (stat_i.span_end) state_d = stat_i.stack_empty ? S_IDLE : S_POP;
      end
      S_POP: begin
        cmd_o.op = OP_POP;
        state_d  = S_WRD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/mrlb_dp.sv
// datapath: word prefix sums, span cost and split tables, walk stack
module mrlb_dp import mrlb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_cmd_t    cmd_i,
  input  logic [7:0] word_length_i,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  output dp_stat_t   stat_o,
  output logic       res_strobe_o,
  output result_t    res_o
);

  // memories
  logic [SumW-1:0]  pre_mem  [MaxWords];
  logic [CostW-1:0] cost_mem [MaxWords*MaxWords];
  logic [IdxW-1:0]  split_mem[MaxWords*MaxWords];
  logic [AddrW-1:0] stk_mem  [MaxWords];

  logic [7:0]       width_q;
  logic [CntW-1:0]  cnt_q, n_q, len_q, sp_q;
  logic [SumW-1:0]  prefix_q;
  logic [IdxW-1:0]  i_q, k_q, kp_q, pick_q, from_q, to_q, w_q;
  logic             kv_q;
  logic [CostW:0]   best_q;
  logic [CostW-1:0] total_q;
  logic [SumW-1:0]  pa_q, pb_q;
  logic [CostW-1:0] ca_q, cb_q;
  logic [IdxW-1:0]  sk_q;
  logic [AddrW-1:0] stk_q;

  logic [IdxW-1:0]  j_w, nm1_w, kp1_w;
  logic [CntW-1:0]  jsum_w;
  logic [AddrW-1:0] ca_addr, cb_addr, span_addr;
  logic [SumW:0]    used_w;
  logic [SumW-1:0]  pbsel_w;
  logic             fits_w, issue_w;
  logic [7:0]       slack_w;
  logic [15:0]      sq_w;
  logic [CostW:0]   sum_w;
  logic [CostW-1:0] sat_w;
  logic [CntW-1:0]  spm1_w;

  // span indices
  assign jsum_w    = {1'b0, i_q} + len_q - CntW'(1);
  assign j_w       = jsum_w[IdxW-1:0];
  assign nm1_w     = IdxW'(n_q - CntW'(1));
  assign kp1_w     = k_q + IdxW'(1);
  assign span_addr = {i_q, j_w};
  assign spm1_w    = sp_q - CntW'(1);

  // fit check and slack cost
  assign pbsel_w = (i_q == '0) ? '0 : pb_q;
  assign used_w  = {1'b0, pa_q - pbsel_w} + (SumW+1)'(len_q) - (SumW+1)'(1);
  assign fits_w  = (used_w <= (SumW+1)'(width_q));
  assign slack_w = width_q - used_w[7:0];
  assign sq_w    = 16'(slack_w) * 16'(slack_w);

  // split candidate sum, saturated
  assign sum_w   = {1'b0, ca_q} + {1'b0, cb_q};
  assign sat_w   = sum_w[CostW] ? CostMax : sum_w[CostW-1:0];
  assign issue_w = (k_q != j_w);

  assign ca_addr = (cmd_i.op == OP_WINIT) ? {{IdxW{1'b0}}, nm1_w} : {i_q, k_q};
  assign cb_addr = {kp1_w, j_w};

  // status to controller
  assign stat_o.span_short  = fits_w || (len_q == CntW'(1));
  assign stat_o.split_done  = !issue_w && !kv_q;
  assign stat_o.last_i      = ({1'b0, i_q} + len_q == n_q);
  assign stat_o.last_len    = (len_q == n_q);
  assign stat_o.leaf        = (sk_q >= to_q);
  assign stat_o.span_end    = (w_q == to_q);
  assign stat_o.stack_empty = (sp_q == '0);

  // result beat
  assign res_strobe_o       = (cmd_i.op == OP_EMIT);
  assign res_o.word_index   = w_q;
  assign res_o.ends_line    = (w_q == to_q);
  assign res_o.total_cost   = total_q;
  assign res_o.last_result  = (w_q == nm1_w);

  // memory read ports, registered
  always_ff @(posedge clk_i) begin
    pa_q  <= pre_mem[j_w];
    pb_q  <= pre_mem[i_q - IdxW'(1)];
    ca_q  <= cost_mem[ca_addr];
    cb_q  <= cost_mem[cb_addr];
    sk_q  <= split_mem[{from_q, to_q}];
    stk_q <= stk_mem[spm1_w[IdxW-1:0]];
  end

  // memory writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD && cnt_q < CntW'(MaxWords)) begin
      pre_mem[cnt_q[IdxW-1:0]] <= prefix_q + SumW'(word_length_i);
    end
    if (cmd_i.op == OP_SEVAL && stat_o.span_short) begin
      cost_mem[span_addr]  <= fits_w ? CostW'(sq_w) : WideCost;
      split_mem[span_addr] <= j_w;
    end
    if (cmd_i.op == OP_SPLIT && stat_o.split_done) begin
      cost_mem[span_addr]  <= best_q[CostW-1:0];
      split_mem[span_addr] <= pick_q;
    end
    if (cmd_i.op == OP_WCHK && !stat_o.leaf) begin
      stk_mem[sp_q[IdxW-1:0]] <= {sk_q + IdxW'(1), to_q};
    end
  end

  // split search payload and walk total
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_SEVAL) begin
      best_q <= {1'b1, {CostW{1'b0}}};
    end else if (cmd_i.op == OP_SPLIT && kv_q && ({1'b0, sat_w} < best_q)) begin
      best_q <= {1'b0, sat_w};
      pick_q <= kp_q;
    end
    if (cmd_i.op == OP_WTOT) total_q <= ca_q;
  end

  // control registers and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 8'd80;
      cnt_q    <= '0;
      n_q      <= '0;
      prefix_q <= '0;
      len_q    <= '0;
      i_q      <= '0;
      k_q      <= '0;
      kp_q     <= '0;
      kv_q     <= 1'b0;
      sp_q     <= '0;
      from_q   <= '0;
      to_q     <= '0;
      w_q      <= '0;
    end else begin
      if (cfg_we_i) width_q <= cfg_data_i;
      case (cmd_i.op)
        OP_LOAD: begin
          if (cnt_q < CntW'(MaxWords)) begin
            prefix_q <= prefix_q + SumW'(word_length_i);
            cnt_q    <= cnt_q + CntW'(1);
          end
        end
        OP_FINIT: begin
          n_q      <= cnt_q;
          cnt_q    <= '0;
          prefix_q <= '0;
          len_q    <= CntW'(1);
          i_q      <= '0;
        end
        OP_SEVAL: begin
          k_q  <= i_q;
          kv_q <= 1'b0;
        end
        OP_SPLIT: begin
          kv_q <= issue_w;
          kp_q <= k_q;
          if (issue_w) k_q <= kp1_w;
        end
        OP_NEXT: begin
          if (stat_o.last_i) begin
            i_q   <= '0;
            len_q <= len_q + CntW'(1);
          end else begin
            i_q <= i_q + IdxW'(1);
          end
        end
        OP_WINIT: begin
          from_q <= '0;
          to_q   <= nm1_w;
          sp_q   <= '0;
        end
        OP_WCHK: begin
          if (stat_o.leaf) begin
            w_q <= from_q;
          end else begin
            sp_q <= sp_q + CntW'(1);
            to_q <= sk_q;
          end
        end
        OP_EMIT: begin
          if (w_q == to_q) begin
            if (sp_q != '0) sp_q <= spm1_w;
          end else begin
            w_q <= w_q + IdxW'(1);
          end
        end
        OP_POP: begin
          from_q <= stk_q[AddrW-1:IdxW];
          to_q   <= stk_q[IdxW-1:0];
        end
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/min_raggedness_line_breaker.sv
// top level of the minimum raggedness line breaker
//
// Usage: words of one paragraph are given one beat at a time on word_item_i,
// taken at a clock edge with start high and busy low. A beat with last_word
// set closes the paragraph; up to 64 words are kept, later ones are dropped.
// busy stays low between words while the paragraph loads.
// After the last word the block fills the span cost table over all spans:
// it reads the prefix sums of a span and costs it, and it searches every
// split point for a span of two or more words that does not fit. It then
// walks the split table: one result beat per word on res_o with
// res_strobe_o high for one cycle. The receiver cannot stall; every beat
// must be taken when shown. busy falls after the beat with last_result set.
// line_width is written on the cfg channel, which is always ready; writes
// belong in idle time. Reset sets line_width to 80 and empties the paragraph.
module min_raggedness_line_breaker import mrlb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  word_item_t word_item_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  output logic       res_strobe_o,
  output result_t    res_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  // sequencer
  mrlb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .last_word_i (word_item_i.last_word),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .busy        (busy)
  );

  // tables and walk
  mrlb_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .word_length_i (word_item_i.word_length),
    .cfg_we_i      (cfg_valid_i & cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .stat_o        (stat),
    .res_strobe_o  (res_strobe_o),
    .res_o         (res_o)
  );

endmodule

// File: dv/tb_min_raggedness_line_breaker.sv
// testbench for the minimum raggedness line breaker: directed table, random paragraphs
`timescale 1ns / 1ps

module tb_min_raggedness_line_breaker;
  import mrlb_pkg::*;

  typedef struct {
    logic [7:0]  len;
    logic        last;
    logic        typed;
    logic [23:0] cost;
  } dir_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  word_item_t word_item_i;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i;
  logic       res_strobe_o;
  result_t    res_o;

  // predictor state
  logic [7:0]  line_width_q;
  logic [7:0]  para_words[MaxWords];
  int unsigned para_count;
  result_t     pending_breaks[$];
  int unsigned error_count;
  bit          gaps_on;

  min_raggedness_line_breaker u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .word_item_i (word_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o)
  );

  // clock, 20 ns period
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // interval dp and ordered walk, pushes one expected beat per word when keep is set
  function automatic void predict_breaks(input bit keep);
    int unsigned cost_tab[MaxWords][MaxWords];
    logic [5:0]  split_tab[MaxWords][MaxWords];
    int unsigned n, span, i, j, k, used, slack, best, s, total, count, w;
    int unsigned stk_from[$];
    int unsigned stk_to[$];
    int unsigned from, to;
    result_t     r;
    n = para_count;
    para_count = 0;
    if (n == 0) return;
    for (span = 1; span <= n; span++) begin
      for (i = 0; i + span <= n; i++) begin
        j = i + span - 1;
        used = j - i;
        for (k = i; k <= j; k++) used += para_words[k];
        if (used <= line_width_q) begin
          slack = line_width_q - used;
          cost_tab[i][j] = slack * slack;
          split_tab[i][j] = j[5:0];
        end else if (i == j) begin
          cost_tab[i][j] = WideCost;
          split_tab[i][j] = j[5:0];
        end else begin
          best = CostMax + 1;
          split_tab[i][j] = i[5:0];
          for (k = i; k < j; k++) begin
            s = cost_tab[i][k] + cost_tab[k+1][j];
            if (s > CostMax) s = CostMax;
            if (s < best) begin
              best = s;
              split_tab[i][j] = k[5:0];
            end
          end
          cost_tab[i][j] = best;
        end
      end
    end
    total = cost_tab[0][n-1];
    count = 0;
    stk_from.push_back(0);
    stk_to.push_back(n - 1);
    while (stk_from.size() > 0 && count < n) begin
      from = stk_from.pop_back();
      to = stk_to.pop_back();
      k = split_tab[from][to];
      if (k >= to || k < from) begin
        for (w = from; w <= to && count < n; w++) begin
          r.word_index  = w[5:0];
          r.ends_line   = (w == to);
          r.total_cost  = total[23:0];
          r.last_result = (w == n - 1);
          if (keep) pending_breaks.push_back(r);
          count++;
        end
      end else if (stk_from.size() + 2 <= MaxWords) begin
        stk_from.push_back(k + 1);
        stk_to.push_back(to);
        stk_from.push_back(from);
        stk_to.push_back(k);
      end
    end
  endfunction

  function automatic void take_word(input logic [7:0] len, input logic last, input bit keep);
    if (para_count < MaxWords) begin
      para_words[para_count] = len;
      para_count++;
    end
    if (last) predict_breaks(keep);
  endfunction

  // one word beat, with an optional random gap before it
  task automatic send_word(input logic [7:0] len, input logic last, input bit keep);
    if (gaps_on && $urandom_range(99) < 8) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    start = 1'b1;
    word_item_i.word_length = len;
    word_item_i.last_word = last;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    take_word(len, last, keep);
    @(negedge clk_i);
    start = 1'b0;
  endtask

  task automatic drain_and_settle();
    while (pending_breaks.size() > 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // line width write, only while idle
  task automatic write_width(input logic [7:0] width);
    drain_and_settle();
    cfg_valid_i = 1'b1;
    cfg_data_i = width;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    line_width_q = width;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_paragraph(input int unsigned words, input int unsigned max_len);
    int unsigned w;
    for (w = 0; w < words; w++)
      send_word(8'($urandom_range(1, max_len)), w == words - 1, 1'b1);
  endtask

  // result checker
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && res_strobe_o) begin
      if (pending_breaks.size() == 0) begin
        report_mismatch("unexpected beat word_index", res_o.word_index, -1);
      end else begin
        want = pending_breaks.pop_front();
        if (res_o.word_index !== want.word_index)
          report_mismatch("word_index", res_o.word_index, want.word_index);
        if (res_o.ends_line !== want.ends_line)
          report_mismatch("ends_line", res_o.ends_line, want.ends_line);
        if (res_o.total_cost !== want.total_cost)
          report_mismatch("total_cost", res_o.total_cost, want.total_cost);
        if (res_o.last_result !== want.last_result)
          report_mismatch("last_result", res_o.last_result, want.last_result);
      end
    end
  end

  // run limit
  initial begin
    #40_000_000;
    $display("min_raggedness_line_breaker verification failed");
    $finish;
  end

  initial begin
    dir_row_t    dir_rows[$];
    result_t     r;
    int unsigned items, words, pick;
    logic [7:0]  widths[6];
    start = 1'b0;
    word_item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    line_width_q = 8'd80;
    para_count = 0;
    error_count = 0;
    gaps_on = 1'b1;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed rows at reset width; single word paragraphs are typed in
    dir_rows = '{
      '{8'd80,  1'b1, 1'b1, 24'd0},
      '{8'd255, 1'b1, 1'b1, 24'd65535},
      '{8'd1,   1'b1, 1'b1, 24'd6241},
      '{8'd40,  1'b0, 1'b0, 24'd0},
      '{8'd39,  1'b1, 1'b0, 24'd0},
      '{8'd50,  1'b0, 1'b0, 24'd0},
      '{8'd50,  1'b1, 1'b0, 24'd0},
      '{8'd255, 1'b0, 1'b0, 24'd0},
      '{8'd255, 1'b0, 1'b0, 24'd0},
      '{8'd1,   1'b1, 1'b0, 24'd0},
      '{8'd10,  1'b0, 1'b0, 24'd0},
      '{8'd20,  1'b0, 1'b0, 24'd0},
      '{8'd30,  1'b0, 1'b0, 24'd0},
      '{8'd5,   1'b0, 1'b0, 24'd0},
      '{8'd70,  1'b0, 1'b0, 24'd0},
      '{8'd12,  1'b1, 1'b0, 24'd0},
      '{8'd170, 1'b0, 1'b0, 24'd0},
      '{8'd85,  1'b1, 1'b0, 24'd0}
    };
    foreach (dir_rows[idx]) begin
      send_word(dir_rows[idx].len, dir_rows[idx].last, !dir_rows[idx].typed);
      if (dir_rows[idx].typed) begin
        r.word_index = '0;
        r.ends_line = 1'b1;
        r.total_cost = dir_rows[idx].cost;
        r.last_result = 1'b1;
        pending_breaks.push_back(r);
      end
    end

    // width extremes, with one-character words and overlong words
    write_width(8'd1);
    send_paragraph(4, 1);
    send_paragraph(3, 3);
    write_width(8'd255);
    send_paragraph(6, 255);
    send_paragraph(2, 127);

    // random paragraphs across several widths
    widths = '{8'd80, 8'd1, 8'd255, 8'd40, 8'd8, 8'd120};
    items = 0;
    while (items < 300) begin
      if ($urandom_range(3) == 0)
        write_width($urandom_range(1) ? widths[$urandom_range(5)] : 8'($urandom_range(1, 255)));
      gaps_on = !(items >= 100 && items < 180);
      pick = $urandom_range(99);
      if (pick < 3) words = $urandom_range(64, 67);
      else if (pick < 8) words = $urandom_range(13, 30);
      else words = $urandom_range(1, 12);
      if ($urandom_range(3) == 0)
        send_paragraph(words, 255);
      else
        send_paragraph(words, (line_width_q > 2) ? line_width_q / 2 : 1);
      items += words;
    end

    while (pending_breaks.size() > 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (error_count == 0) begin
      $display("min_raggedness_line_breaker verification clean");
    end else begin
      $display("min_raggedness_line_breaker verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/mrlb_pkg.sv
rtl/mrlb_ctrl.sv
rtl/mrlb_dp.sv
rtl/min_raggedness_line_breaker.sv
dv/tb_min_raggedness_line_breaker.sv
